### sv/mtls_pkg.sv
// Package for the multirate time-step level scheduler: sizes, codes and shared types.
`default_nettype none

package mtls_pkg;

	// Grid and level configuration.
	localparam int unsigned SIZE_X = 32;
	localparam int unsigned SIZE_Y = 32;
	localparam int unsigned SIZE_Z = 32;
	localparam int NUM_LEVELS = 8;
	localparam int RATE_BITS = 32;

	// Derived sizes.
	localparam int unsigned NCELLS = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int ADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PHASE_W = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;
	localparam int RATE_W = (RATE_BITS < 32) ? RATE_BITS : 32;
	localparam int NUM_SLOTS = 3;
	localparam int SLOT_W = 2;

	// Command codes.
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_UPDATE    = 3'd1,
		CMD_CELL_ACT  = 3'd2,
		CMD_NBR_ACT   = 3'd3,
		CMD_FACE_ACT  = 3'd4,
		CMD_CELL_MULT = 3'd5,
		CMD_FACE_MULT = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	// Axis codes; the fourth code is invalid.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Read slots: the cell itself, the lower neighbor and the upper neighbor.
	localparam logic [SLOT_W-1:0] SLOT_CELL = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_LO = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_HI = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_ACC,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic clr_en;
		logic acc_clr;
		logic rd_en;
		logic acc_en;
		logic upd_en;
		logic ld_result;
		logic phase_inc;
		logic [SLOT_W-1:0] slot;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_tick;
		logic is_nop;
		logic is_bad;
		logic is_update;
		logic [NUM_SLOTS-1:0] slot_en;
	} dp_status_t;

endpackage

`default_nettype wire

### sv/mtls_ctrl.sv
// Controller state machine of the multirate time-step level scheduler.
`default_nettype none

module mtls_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mtls_pkg::dp_status_t status,
	output mtls_pkg::ctrl_cmd_t      ctrl,
	output logic                     busy
);

	mtls_pkg::state_t state_q, state_d;
	logic [mtls_pkg::SLOT_W-1:0] slot_q, slot_d;

	// Next enabled read slot, searched from the cell slot in decode and past the current one later.
	logic [mtls_pkg::SLOT_W-1:0] lo_slot;
	logic [mtls_pkg::SLOT_W-1:0] pick_slot;
	logic pick_ok;

	always_comb begin
		lo_slot = (state_q == mtls_pkg::ST_DECODE) ? mtls_pkg::SLOT_CELL
			: mtls_pkg::SLOT_W'(slot_q + 1'b1);
		pick_ok = 1'b0;
		pick_slot = mtls_pkg::SLOT_CELL;
		for (int i = mtls_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (status.slot_en[i] && (mtls_pkg::SLOT_W'(i) >= lo_slot)) begin
				pick_ok = 1'b1;
				pick_slot = mtls_pkg::SLOT_W'(i);
			end
		end
	end

	// Next state and slot.
	always_comb begin
		state_d = state_q;
		slot_d = slot_q;
		unique case (state_q)
			mtls_pkg::ST_CLEAR: begin
				if (status.clr_last) state_d = mtls_pkg::ST_IDLE;
			end
			mtls_pkg::ST_IDLE: begin
				if (start) state_d = mtls_pkg::ST_DECODE;
			end
			mtls_pkg::ST_DECODE: begin
				if (status.is_tick || status.is_nop || status.is_bad || !pick_ok) begin
					state_d = mtls_pkg::ST_DONE;
				end else begin
					state_d = mtls_pkg::ST_READ;
					slot_d = pick_slot;
				end
			end
			mtls_pkg::ST_READ: begin
				state_d = mtls_pkg::ST_ACC;
			end
			mtls_pkg::ST_ACC: begin
				if (status.is_update) begin
					state_d = mtls_pkg::ST_UPDATE;
				end else if (pick_ok) begin
					state_d = mtls_pkg::ST_READ;
					slot_d = pick_slot;
				end else begin
					state_d = mtls_pkg::ST_DONE;
				end
			end
			mtls_pkg::ST_UPDATE: begin
				state_d = mtls_pkg::ST_DONE;
			end
			mtls_pkg::ST_DONE: begin
				state_d = mtls_pkg::ST_IDLE;
			end
			default: state_d = mtls_pkg::ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		ctrl = '0;
		ctrl.slot = slot_q;
		busy = 1'b1;
		unique case (state_q)
			mtls_pkg::ST_CLEAR: ctrl.clr_en = 1'b1;
			mtls_pkg::ST_IDLE: begin
				busy = 1'b0;
				ctrl.latch = start;
			end
			mtls_pkg::ST_DECODE: begin
				ctrl.acc_clr = 1'b1;
				ctrl.phase_inc = status.is_tick;
			end
			mtls_pkg::ST_READ: ctrl.rd_en = 1'b1;
			mtls_pkg::ST_ACC: ctrl.acc_en = 1'b1;
			mtls_pkg::ST_UPDATE: ctrl.upd_en = 1'b1;
			mtls_pkg::ST_DONE: ctrl.ld_result = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtls_pkg::ST_CLEAR;
			slot_q <= mtls_pkg::SLOT_CELL;
		end else begin
			state_q <= state_d;
			slot_q <= slot_d;
		end
	end

endmodule

`default_nettype wire

### sv/mtls_datapath.sv
// Datapath of the multirate time-step level scheduler: level store, phase and result logic.
`default_nettype none

module mtls_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mtls_pkg::ctrl_cmd_t ctrl,
	input  wire logic [2:0]          cmd,
	input  wire logic [5:0]          cell_x,
	input  wire logic [5:0]          cell_y,
	input  wire logic [5:0]          cell_z,
	input  wire logic [1:0]          axis,
	input  wire logic [31:0]         cell_rate,
	input  wire logic [31:0]         max_rate,
	output mtls_pkg::dp_status_t     status,
	output logic                     done,
	output logic                     active,
	output logic [2:0]               level,
	output logic [7:0]               multiplier,
	output logic                     written,
	output logic                     bad_index
);

	localparam int LW = mtls_pkg::LVL_W;
	localparam int PW = mtls_pkg::PHASE_W;
	localparam int RW = mtls_pkg::RATE_W;
	localparam int TW = mtls_pkg::RATE_W + mtls_pkg::NUM_LEVELS;

	// A level is active when the phase is a multiple of two to that level.
	function automatic logic level_active(input logic [LW-1:0] lv, input logic [PW-1:0] ph);
		logic r;
		r = 1'b1;
		for (int i = 0; i < PW; i++) begin
			if ((i < int'(lv)) && ph[i]) r = 1'b0;
		end
		return r;
	endfunction

	// Largest level whose scaled rate still fits under the maximum rate.
	function automatic logic [LW-1:0] target_level(input logic [RW-1:0] r,
			input logic [RW-1:0] m);
		logic [LW-1:0] lv;
		lv = '0;
		if (r == '0) begin
			lv = LW'(mtls_pkg::NUM_LEVELS - 1);
		end else begin
			for (int l = 1; l < mtls_pkg::NUM_LEVELS; l++) begin
				if ((TW'(r) << l) <= TW'(m)) lv = LW'(l);
			end
		end
		return lv;
	endfunction

	// Latched item fields.
	mtls_pkg::cmd_t cmd_q;
	logic [5:0] x_q, y_q, z_q;
	logic [1:0] axis_q;
	logic [RW-1:0] rate_q, maxr_q;

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= mtls_pkg::cmd_t'(cmd);
			x_q <= cell_x;
			y_q <= cell_y;
			z_q <= cell_z;
			axis_q <= axis;
			rate_q <= cell_rate[RW-1:0];
			maxr_q <= max_rate[RW-1:0];
		end
	end

	// Command classes.
	logic is_face, is_cell;
	always_comb begin
		is_face = 1'b0;
		is_cell = 1'b0;
		case (cmd_q)
			mtls_pkg::CMD_FACE_ACT, mtls_pkg::CMD_FACE_MULT: is_face = 1'b1;
			mtls_pkg::CMD_UPDATE, mtls_pkg::CMD_CELL_ACT, mtls_pkg::CMD_NBR_ACT,
			mtls_pkg::CMD_CELL_MULT: is_cell = 1'b1;
			default: ;
		endcase
	end

	// Coordinate along the chosen axis and the grid size there.
	logic [6:0] ax_c;
	int unsigned ax_size;
	logic axis_bad;
	always_comb begin
		ax_c = {1'b0, z_q};
		ax_size = mtls_pkg::SIZE_Z;
		axis_bad = 1'b0;
		unique case (axis_q)
			mtls_pkg::AXIS_X: begin
				ax_c = {1'b0, x_q};
				ax_size = mtls_pkg::SIZE_X;
			end
			mtls_pkg::AXIS_Y: begin
				ax_c = {1'b0, y_q};
				ax_size = mtls_pkg::SIZE_Y;
			end
			mtls_pkg::AXIS_Z: begin
				ax_c = {1'b0, z_q};
				ax_size = mtls_pkg::SIZE_Z;
			end
			default: axis_bad = 1'b1;
		endcase
	end

	// Index checks for cell and face commands.
	logic x_in, y_in, z_in, cell_ok, face_ok, bad_now;
	always_comb begin
		x_in = 32'(x_q) < mtls_pkg::SIZE_X;
		y_in = 32'(y_q) < mtls_pkg::SIZE_Y;
		z_in = 32'(z_q) < mtls_pkg::SIZE_Z;
		cell_ok = x_in && y_in && z_in;
		face_ok = !axis_bad;
		unique case (axis_q)
			mtls_pkg::AXIS_X: face_ok = (32'(x_q) <= mtls_pkg::SIZE_X) && y_in && z_in;
			mtls_pkg::AXIS_Y: face_ok = x_in && (32'(y_q) <= mtls_pkg::SIZE_Y) && z_in;
			mtls_pkg::AXIS_Z: face_ok = x_in && y_in && (32'(z_q) <= mtls_pkg::SIZE_Z);
			default: face_ok = 1'b0;
		endcase
		bad_now = (is_face && !face_ok) || (is_cell && !cell_ok)
			|| ((cmd_q == mtls_pkg::CMD_NBR_ACT) && axis_bad);
	end

	// Which slots need a read.
	logic [mtls_pkg::NUM_SLOTS-1:0] slot_en;
	always_comb begin
		slot_en[mtls_pkg::SLOT_CELL] = is_cell;
		slot_en[mtls_pkg::SLOT_LO] = (is_face || (cmd_q == mtls_pkg::CMD_NBR_ACT))
			&& (ax_c != '0);
		if (cmd_q == mtls_pkg::CMD_NBR_ACT) begin
			slot_en[mtls_pkg::SLOT_HI] = (32'(ax_c) + 32'd1) < ax_size;
		end else begin
			slot_en[mtls_pkg::SLOT_HI] = is_face && (32'(ax_c) < ax_size);
		end
	end

	assign status.is_tick = (cmd_q == mtls_pkg::CMD_TICK);
	assign status.is_nop = (cmd_q == mtls_pkg::CMD_NONE);
	assign status.is_bad = bad_now;
	assign status.is_update = (cmd_q == mtls_pkg::CMD_UPDATE);
	assign status.slot_en = slot_en;

	// Coordinates of the current slot and its store address.
	logic [6:0] slot_c, xs, ys, zs;
	int unsigned addr_full;
	logic [mtls_pkg::ADDR_W-1:0] cur_addr;
	always_comb begin
		slot_c = ax_c;
		case (ctrl.slot)
			mtls_pkg::SLOT_LO: slot_c = ax_c - 7'd1;
			mtls_pkg::SLOT_HI: slot_c = (cmd_q == mtls_pkg::CMD_NBR_ACT) ? ax_c + 7'd1 : ax_c;
			default: slot_c = ax_c;
		endcase
		xs = {1'b0, x_q};
		ys = {1'b0, y_q};
		zs = {1'b0, z_q};
		case (axis_q)
			mtls_pkg::AXIS_X: xs = slot_c;
			mtls_pkg::AXIS_Y: ys = slot_c;
			mtls_pkg::AXIS_Z: zs = slot_c;
			default: ;
		endcase
		addr_full = (32'(xs) * mtls_pkg::SIZE_Y + 32'(ys)) * mtls_pkg::SIZE_Z + 32'(zs);
		cur_addr = addr_full[mtls_pkg::ADDR_W-1:0];
	end

	// Clearing pass over the store after reset.
	logic [mtls_pkg::ADDR_W-1:0] clr_cnt_q;
	assign status.clr_last = (32'(clr_cnt_q) == mtls_pkg::NCELLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctrl.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Tick phase counter.
	logic [PW-1:0] phase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctrl.phase_inc) begin
			phase_q <= phase_q + 1'b1;
		end
	end

	// Level update: from an active level, climb to highest active level <= target, or drop to it.
	logic [LW-1:0] old_q, target_q, climb, new_lv;
	logic old_act, upd_write;
	always_comb begin
		old_act = level_active(old_q, phase_q);
		climb = old_q;
		for (int l = 0; l < mtls_pkg::NUM_LEVELS; l++) begin
			if ((l > int'(old_q)) && (l <= int'(target_q)) && level_active(LW'(l), phase_q)) begin
				climb = LW'(l);
			end
		end
		if (!old_act) begin
			new_lv = old_q;
		end else if (target_q > old_q) begin
			new_lv = climb;
		end else begin
			new_lv = target_q;
		end
		upd_write = ctrl.upd_en && old_act && (new_lv != old_q);
	end

	// Level store: one write port shared by the clearing pass and updates, one read port.
	logic [LW-1:0] level_mem_q [mtls_pkg::NCELLS];
	logic [LW-1:0] rd_data_q;
	logic mem_we;
	logic [mtls_pkg::ADDR_W-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;

	assign mem_we = ctrl.clr_en || upd_write;
	assign mem_waddr = ctrl.clr_en ? clr_cnt_q : cur_addr;
	assign mem_wdata = ctrl.clr_en ? '0 : new_lv;

	always_ff @(posedge clk) begin
		if (mem_we) level_mem_q[mem_waddr] <= mem_wdata;
		if (ctrl.rd_en) rd_data_q <= level_mem_q[cur_addr];
	end

	// Accumulation over the read slots.
	logic act_q, have_q, wr_q;
	logic [LW-1:0] min_q, new_q;

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			act_q <= 1'b0;
			have_q <= 1'b0;
			min_q <= '0;
			old_q <= '0;
			target_q <= target_level(rate_q, maxr_q);
		end else if (ctrl.acc_en) begin
			if (level_active(rd_data_q, phase_q)) act_q <= 1'b1;
			if (ctrl.slot == mtls_pkg::SLOT_CELL) begin
				old_q <= rd_data_q;
			end else begin
				have_q <= 1'b1;
				if (!have_q || (rd_data_q < min_q)) min_q <= rd_data_q;
			end
		end
		if (ctrl.upd_en) begin
			new_q <= new_lv;
			wr_q <= old_act && (new_lv != old_q);
		end
	end

	// Result selection.
	logic r_act, r_wr, r_bad;
	logic [LW-1:0] r_lv;
	logic [7:0] r_mult;
	always_comb begin
		r_act = 1'b0;
		r_wr = 1'b0;
		r_bad = 1'b0;
		r_lv = '0;
		r_mult = 8'd0;
		if (bad_now) begin
			r_bad = 1'b1;
		end else if (is_face) begin
			if (!have_q) begin
				r_bad = 1'b1;
				r_mult = 8'd1;
			end else begin
				r_act = (cmd_q == mtls_pkg::CMD_FACE_ACT) && act_q;
				r_lv = min_q;
				r_mult = 8'd1 << r_lv;
			end
		end else if (is_cell) begin
			if (cmd_q == mtls_pkg::CMD_UPDATE) begin
				r_lv = new_q;
				r_wr = wr_q;
			end else begin
				r_lv = old_q;
				r_act = ((cmd_q == mtls_pkg::CMD_CELL_ACT) || (cmd_q == mtls_pkg::CMD_NBR_ACT))
					&& act_q;
			end
			r_mult = 8'd1 << r_lv;
		end
	end

	// Result registers, loaded with done and held until the next result; done is high for one cycle.
	always_ff @(posedge clk) begin
		if (ctrl.ld_result) begin
			active <= r_act;
			level <= 3'(r_lv);
			multiplier <= r_mult;
			written <= r_wr;
			bad_index <= r_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl.ld_result;
		end
	end

endmodule

`default_nettype wire

### sv/multirate_timestep_level_scheduler_top.sv
// Top level of the multirate time-step level scheduler.
//
// A command item is taken at a rising edge where start is high and busy is low.
// Each item gives exactly one result: done is high for one cycle and active,
// level, multiplier, written and bad_index are valid in that cycle. The
// receiver cannot hold results off; busy is low again in the done cycle, so
// the next item may be taken at the edge that ends it.
// An item runs through decode, a read and an accumulate state per store
// read, an update state for an update, and a done state; no new item is
// taken before its done cycle. A tick, an invalid index or an unused code
// needs no store read, a cell query or multiplier read one, an update one,
// a face command up to two and a cell-or-neighbor query up to three. The
// single read port of the level store, whose data is registered before it
// is accumulated, sets this sequence. After reset the store is swept to
// level zero, one entry a cycle, over all 32768 entries; busy stays high
// during the sweep. The tick phase resets to zero.
`default_nettype none

module multirate_timestep_level_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [5:0]  cell_x,
	input  wire logic [5:0]  cell_y,
	input  wire logic [5:0]  cell_z,
	input  wire logic [1:0]  axis,
	input  wire logic [31:0] cell_rate,
	input  wire logic [31:0] max_rate,
	output logic             done,
	output logic             active,
	output logic [2:0]       level,
	output logic [7:0]       multiplier,
	output logic             written,
	output logic             bad_index
);

	mtls_pkg::ctrl_cmd_t ctrl;
	mtls_pkg::dp_status_t status;

	// Sequencing of reads, updates and results.
	mtls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Level store, phase counter and result logic.
	mtls_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cmd        (cmd),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.axis       (axis),
		.cell_rate  (cell_rate),
		.max_rate   (max_rate),
		.status     (status),
		.done       (done),
		.active     (active),
		.level      (level),
		.multiplier (multiplier),
		.written    (written),
		.bad_index  (bad_index)
	);

endmodule

`default_nettype wire
